// File: src/ptt_pkg.sv
// Shared types, widths and codes for the point-in-tetrahedron test.
// Used by the controller, the datapath and the top level; no dependencies.

package ptt_pkg;

  localparam int COORD_BITS      = 16;
  localparam int SLACK_FRAC_BITS = 20;
  localparam int CFG_W           = 20;
  localparam logic [CFG_W-1:0] SLACK_RESET = CFG_W'(105);

  localparam int ROLE_W    = 3;
  localparam int NUM_VERTS = 4;
  localparam int VIDX_W    = $clog2(NUM_VERTS);
  localparam logic [ROLE_W-1:0] ROLE_QUERY = ROLE_W'(NUM_VERTS);

  localparam int IN_TDATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  // Arithmetic widths, all exact for the coordinate range.
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int COF_W    = PROD_W + 1;
  localparam int TERM_W   = DIFF_W + COF_W;
  localparam int DET_W    = TERM_W + 2;
  localparam int VOL_W    = DET_W;
  localparam int SUM_W    = VOL_W + 2;
  localparam int FACTOR_W = ((SLACK_FRAC_BITS > CFG_W) ? SLACK_FRAC_BITS : CFG_W) + 1;
  localparam int VLO_W    = VOL_W / 2;
  localparam int VHI_W    = VOL_W - VLO_W;
  localparam int MPROD_W  = VHI_W + FACTOR_W;
  localparam int RHS_W    = VOL_W + FACTOR_W + 1;
  localparam int LHS_W    = SUM_W + SLACK_FRAC_BITS;
  localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // Five triple products per query: the volume first, then one per face.
  localparam int NUM_DETS = 5;
  localparam int DET_CNT_W = $clog2(NUM_DETS);
  typedef logic [DET_CNT_W-1:0] det_idx_t;
  localparam det_idx_t DET_VOL     = DET_CNT_W'(0);
  localparam det_idx_t DET_FACE0   = DET_CNT_W'(2);
  localparam det_idx_t DET_FACE1   = DET_CNT_W'(3);
  localparam det_idx_t DET_FACE2   = DET_CNT_W'(4);
  localparam det_idx_t DET_LAST    = DET_CNT_W'(NUM_DETS - 1);

  // Final count of the drain state, which waits until the last issued product is accumulated.
  localparam det_idx_t DRAIN_LAST = DET_CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_MUL_LO,
    S_MUL_HI,
    S_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic     load_vtx;
    logic     start;
    logic     issue;
    det_idx_t det_sel;
    logic     mul_lo;
    logic     mul_hi;
    logic     res_load;
  } ptt_cmd_t;

endpackage

// File: src/ptt_ctrl.sv
// Sequencer for the point-in-tetrahedron test: input and output handshakes
// and the command schedule of the datapath. Depends on ptt_pkg.

module ptt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [ptt_pkg::ROLE_W-1:0]    role_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output ptt_pkg::ptt_cmd_t             cmd_o
);
  import ptt_pkg::*;

  ctrl_state_e state_q, state_d;
  det_idx_t    cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        res_free;

  assign accept   = s_valid_i && s_ready_o;
  assign res_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept && role_i == ROLE_QUERY) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (cnt_q == DET_LAST) begin
          state_d = S_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + DET_CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (cnt_q == DRAIN_LAST) begin
          state_d = S_MUL_LO;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + DET_CNT_W'(1);
        end
      end
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_RESULT;
      S_RESULT: begin
        if (res_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o        = (state_q == S_IDLE);
    cmd_o.load_vtx   = accept && (role_i < ROLE_QUERY);
    cmd_o.start      = accept && (role_i == ROLE_QUERY);
    cmd_o.issue      = (state_q == S_ISSUE);
    cmd_o.det_sel    = cnt_q;
    cmd_o.mul_lo     = (state_q == S_MUL_LO);
    cmd_o.mul_hi     = (state_q == S_MUL_HI);
    cmd_o.res_load   = (state_q == S_RESULT) && res_free;
  end

  // The result register holds one request until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == S_ISSUE && cnt_q == DET_VOL))
    else $error("query request did not start the determinant sequence");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_vtx |=> (state_q == S_IDLE))
    else $error("vertex load left the idle state");

  a_drain_then_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && cmd_o.det_sel == DET_LAST) |-> ##3 cmd_o.mul_lo)
    else $error("final product not drained before the slack multiply");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || m_ready_i))
    else $error("pending result overwritten");

endmodule

// File: src/ptt_datapath.sv
// Datapath of the point-in-tetrahedron test: vertex store, a pipelined
// triple-product unit shared by all five determinants, the slack multiply
// and the final compare. Depends on ptt_pkg.

module ptt_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ptt_pkg::ptt_cmd_t                  cmd_i,
  input  logic [ptt_pkg::ROLE_W-1:0]         role_i,
  input  logic [ptt_pkg::IN_TDATA_W-1:0]     coords_i,
  input  logic                               cfg_we_i,
  input  logic [ptt_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                               inside_o,
  output logic                               degenerate_o
);
  import ptt_pkg::*;

  logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
  logic signed [COORD_BITS-1:0] vtx_q [NUM_VERTS][3];
  logic signed [COORD_BITS-1:0] pt_q [3];
  logic [CFG_W-1:0]             slack_q;

  assign in_x = coords_i[COORD_BITS-1:0];
  assign in_y = coords_i[2*COORD_BITS-1:COORD_BITS];
  assign in_z = coords_i[3*COORD_BITS-1:2*COORD_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VERTS; i++) begin
        for (int j = 0; j < 3; j++) begin
          vtx_q[i][j] <= '0;
        end
      end
      slack_q <= SLACK_RESET;
    end else begin
      if (cmd_i.load_vtx) begin
        vtx_q[role_i[VIDX_W-1:0]][0] <= in_x;
        vtx_q[role_i[VIDX_W-1:0]][1] <= in_y;
        vtx_q[role_i[VIDX_W-1:0]][2] <= in_z;
      end
      if (cfg_we_i) begin
        slack_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pt_q[0] <= in_x;
      pt_q[1] <= in_y;
      pt_q[2] <= in_z;
    end
  end

  // Row selection. The volume uses edges from vertex 0. Face rows are taken
  // from the point to vertices 1 to 3; three faces swap one for vertex 0.
  logic signed [DIFF_W-1:0] ra [3];
  logic signed [DIFF_W-1:0] rb [3];
  logic signed [DIFF_W-1:0] rc [3];
  logic signed [COORD_BITS-1:0] sub_v;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sub_v = (cmd_i.det_sel == DET_VOL) ? vtx_q[0][j] : pt_q[j];
      ra[j] = DIFF_W'((cmd_i.det_sel == DET_FACE0) ? vtx_q[0][j] : vtx_q[1][j])
              - DIFF_W'(sub_v);
      rb[j] = DIFF_W'((cmd_i.det_sel == DET_FACE1) ? vtx_q[0][j] : vtx_q[2][j])
              - DIFF_W'(sub_v);
      rc[j] = DIFF_W'((cmd_i.det_sel == DET_FACE2) ? vtx_q[0][j] : vtx_q[3][j])
              - DIFF_W'(sub_v);
    end
  end

  // Stage 1: cofactors of the first column.
  logic signed [PROD_W-1:0] p_bc, p_cb, p_ac, p_ca, p_ab, p_ba;
  assign p_bc = rb[1] * rc[2];
  assign p_cb = rc[1] * rb[2];
  assign p_ac = ra[1] * rc[2];
  assign p_ca = rc[1] * ra[2];
  assign p_ab = ra[1] * rb[2];
  assign p_ba = rb[1] * ra[2];

  logic signed [DIFF_W-1:0] s1_a_q, s1_b_q, s1_c_q;
  logic signed [COF_W-1:0]  s1_cof0_q, s1_cof1_q, s1_cof2_q;
  logic                     s1_vld_q, s1_vol_q;

  always_ff @(posedge clk_i) begin
    s1_a_q    <= ra[0];
    s1_b_q    <= rb[0];
    s1_c_q    <= rc[0];
    s1_cof0_q <= COF_W'(p_bc) - COF_W'(p_cb);
    s1_cof1_q <= COF_W'(p_ac) - COF_W'(p_ca);
    s1_cof2_q <= COF_W'(p_ab) - COF_W'(p_ba);
  end

  // Stage 2: expansion terms.
  logic signed [TERM_W-1:0] t_a, t_b, t_c;
  logic signed [TERM_W-1:0] s2_ta_q, s2_tb_q, s2_tc_q;
  logic                     s2_vld_q, s2_vol_q;

  assign t_a = s1_a_q * s1_cof0_q;
  assign t_b = s1_b_q * s1_cof1_q;
  assign t_c = s1_c_q * s1_cof2_q;

  always_ff @(posedge clk_i) begin
    s2_ta_q <= t_a;
    s2_tb_q <= t_b;
    s2_tc_q <= t_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_vol_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s2_vol_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s1_vol_q <= (cmd_i.det_sel == DET_VOL);
      s2_vld_q <= s1_vld_q;
      s2_vol_q <= s1_vol_q;
    end
  end

  // Stage 3: determinant magnitude into the volume or the face sum.
  logic signed [DET_W-1:0] det;
  logic [VOL_W-1:0]        det_abs;
  logic [VOL_W-1:0]        vol_q;
  logic [SUM_W-1:0]        sum_q;

  assign det     = DET_W'(s2_ta_q) - DET_W'(s2_tb_q) + DET_W'(s2_tc_q);
  assign det_abs = det[DET_W-1] ? VOL_W'(-det) : VOL_W'(det);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sum_q <= '0;
    end else if (s2_vld_q && !s2_vol_q) begin
      sum_q <= sum_q + SUM_W'(det_abs);
    end
    if (s2_vld_q && s2_vol_q) begin
      vol_q <= det_abs;
    end
  end

  // Volume times (one plus slack), as two half-width partial products
  // through one multiplier.
  logic [FACTOR_W-1:0] factor;
  logic [VHI_W-1:0]    mop;
  logic [MPROD_W-1:0]  mprod;
  logic [MPROD_W-1:0]  plo_q;
  logic [RHS_W-1:0]    rhs_q;

  assign factor = (FACTOR_W'(1) << SLACK_FRAC_BITS) + FACTOR_W'(slack_q);
  assign mop    = cmd_i.mul_hi ? vol_q[VOL_W-1:VLO_W] : VHI_W'(vol_q[VLO_W-1:0]);
  assign mprod  = MPROD_W'(mop) * MPROD_W'(factor);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      plo_q <= mprod;
    end
    if (cmd_i.mul_hi) begin
      rhs_q <= RHS_W'(plo_q) + (RHS_W'(mprod) << VLO_W);
    end
  end

  logic [CMP_W-1:0] lhs_ext, rhs_ext;
  logic             vol_zero;
  logic             inside_q, degen_q;

  assign lhs_ext  = CMP_W'(sum_q) << SLACK_FRAC_BITS;
  assign rhs_ext  = CMP_W'(rhs_q);
  assign vol_zero = (vol_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      inside_q <= !vol_zero && (lhs_ext < rhs_ext);
      degen_q  <= vol_zero;
    end
  end

  assign inside_o     = inside_q;
  assign degenerate_o = degen_q;

endmodule

// File: src/point_in_tetrahedron_test.sv
// Top level of the point-in-tetrahedron test: streaming ports and the
// configuration write channel. Depends on ptt_pkg, ptt_ctrl, ptt_datapath.
//
// Usage. Each input request carries a role in s_axis_tuser and a point in
// s_axis_tdata. Roles 0 to 3 store that vertex of the tetrahedron and give no
// result; role 4 tests the point against the stored tetrahedron and gives one
// result on the master side; roles 5 to 7 are dropped. A vertex load leaves
// the block idle, so the next request can follow at once. A query occupies
// the shared determinant pipeline: it issues five determinants, drains the
// three stages, runs the split slack multiply as a low and a high step and
// then the compare; no new request is taken until the result is loaded into
// the output register, at which point the block is idle again.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits; a query that finishes while that
// register is full waits in its compare step until the receiver takes it.
// Reset clears the vertices to zero and sets the slack register to 105.
// The slack register is written through cfg_valid_i and cfg_data_i; it is
// always ready and should be written while no query is in progress.

module point_in_tetrahedron_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // x_coord, y_coord, z_coord from the lowest bit up
  input  logic [ptt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // role
  input  logic [ptt_pkg::ROLE_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // inside_res, degenerate from the lowest bit up, zero padded
  output logic [ptt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ptt_pkg::CFG_W-1:0]          cfg_data_i
);
  import ptt_pkg::*;

  ptt_cmd_t cmd;
  logic     inside_res;
  logic     degenerate;

  assign cfg_ready_o = 1'b1;

  ptt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .role_i    (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  ptt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .role_i       (s_axis_tuser),
    .coords_i     (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .inside_o     (inside_res),
    .degenerate_o (degenerate)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 2)'(0), degenerate, inside_res};

endmodule

// File: bench/tb.sv
// Self-checking bench for point_in_tetrahedron_test: streams vertex loads and
// queries with random idling and checks every result against its own model.
// Depends on ptt_pkg and the point_in_tetrahedron_test RTL.

module tb;
  import ptt_pkg::*;

  localparam int LIMIT        = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 445;

  typedef longint vec_t [3];
  typedef struct {
    bit in_tet;
    bit degen;
    int qnum;
  } verdict_t;

  class inside_scoreboard;
    longint           vtx [4][3];
    logic [CFG_W-1:0] slack;
    verdict_t         verdicts [$];
    int               fails, loads, queries, dropped, n_inside, n_degen;

    function new();
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) vtx[i][j] = 0;
      end
      slack = SLACK_RESET;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    // Magnitude of the triple product of three rows; exact in 64 bits here.
    function longint triple_mag(vec_t a, vec_t b, vec_t c);
      longint c0, c1, c2, d;
      c0 = b[1] * c[2] - c[1] * b[2];
      c1 = a[1] * c[2] - c[1] * a[2];
      c2 = a[1] * b[2] - b[1] * a[2];
      d  = a[0] * c0 - b[0] * c1 + c[0] * c2;
      return (d < 0) ? -d : d;
    endfunction

    function void note_request(logic [ROLE_W-1:0] role, logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y,
                               logic signed [COORD_BITS-1:0] z);
      vec_t       pt, e1, e2, e3;
      vec_t       q [4];
      longint     vol, sum;
      logic [127:0] lhs, rhs, factor;
      verdict_t   v;
      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      if (role < ROLE_QUERY) begin
        for (int i = 0; i < 3; i++) vtx[role][i] = pt[i];
        loads++;
        return;
      end
      if (role != ROLE_QUERY) begin
        dropped++;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        e1[i] = vtx[1][i] - vtx[0][i];
        e2[i] = vtx[2][i] - vtx[0][i];
        e3[i] = vtx[3][i] - vtx[0][i];
        for (int k = 0; k < 4; k++) q[k][i] = vtx[k][i] - pt[i];
      end
      vol = triple_mag(e1, e2, e3);
      sum = triple_mag(q[1], q[2], q[3]) + triple_mag(q[0], q[2], q[3])
          + triple_mag(q[1], q[0], q[3]) + triple_mag(q[1], q[2], q[0]);
      lhs    = 128'(sum) << SLACK_FRAC_BITS;
      factor = (128'(1) << SLACK_FRAC_BITS) + 128'(slack);
      rhs    = 128'(vol) * factor;
      v.qnum   = queries;
      v.degen  = (vol == 0);
      v.in_tet = !v.degen && (lhs < rhs);
      n_inside += v.in_tet;
      n_degen  += v.degen;
      queries++;
      verdicts.push_back(v);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      fails++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report($sformatf("result 0x%02h arrived with no query outstanding", data));
      end else begin
        v = verdicts.pop_front();
        if (data[0] !== v.in_tet)
          report($sformatf("query %0d: inside_res %b, model %b", v.qnum, data[0], v.in_tet));
        if (data[1] !== v.degen)
          report($sformatf("query %0d: degenerate %b, model %b", v.qnum, data[1], v.degen));
        if (data[OUT_TDATA_W-1:2] !== '0)
          report($sformatf("query %0d: padding bits 0x%02h not zero", v.qnum, data));
      end
    endtask
  endclass

  logic                   clk_i, rst_ni;
  logic                   s_axis_tvalid, s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [ROLE_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid, m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i, cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;

  inside_scoreboard sb = new();
  int  src_idle_pct, snk_stall_pct, items_sent;
  bit  pressure_armed;
  logic hold_off;

  point_in_tetrahedron_test dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run watchdog.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d results outstanding",
             cycles, sb.pending());
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                      s_axis_tdata[47:32]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // The receiver goes quiet for a long stretch while queries keep coming, so
  // the output register fills and the block has to stall its input.
  initial begin
    int held;
    wait (pressure_armed);
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b1;
    held = 0;
    while (held < HOLD_CYCLES) begin
      @(posedge clk_i);
      held++;
    end
    hold_off <= 1'b0;
  end

  function automatic int rnd16();
    logic signed [COORD_BITS-1:0] r;
    r = COORD_BITS'($urandom);
    return int'(r);
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rnd_within(int s);
    return int'($urandom_range(2 * s)) - s;
  endfunction

  task automatic send_item(logic [ROLE_W-1:0] role, int x, int y, int z);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= role;
    s_axis_tdata  <= {16'(z), 16'(y), 16'(x)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (role <= ROLE_QUERY) items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_slack(logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.slack = value;
  endtask

  task automatic run_directed();
    // Zero volume right after reset, with every vertex still at the origin.
    send_item(ROLE_QUERY, 0, 0, 0);
    send_item(ROLE_W'(0), -32768, -32768, -32768);
    send_item(ROLE_W'(1), 32767, -32768, -32768);
    send_item(ROLE_W'(2), -32768, 32767, -32768);
    send_item(ROLE_W'(3), -32768, -32768, 32767);
    // On a vertex the face volumes add up to the full volume exactly.
    send_item(ROLE_QUERY, -32768, -32768, -32768);
    send_item(ROLE_QUERY, -16384, -16384, -16384);
    send_item(ROLE_QUERY, 32767, 32767, 32767);
    send_item(ROLE_QUERY, -1, -1, -1);
    send_item(ROLE_QUERY, -32768, 0, -32768);
    send_item(ROLE_QUERY, 0, -32768, -32768);
    send_item(ROLE_W'(ROLE_QUERY + 1), 32767, -1, -32768);
    send_item(ROLE_W'(ROLE_QUERY + 2), -1, -32768, 32767);
    send_item(ROLE_W'(ROLE_QUERY + 3), -32768, 32767, -1);
    // Two equal vertices make the tetrahedron flat.
    send_item(ROLE_W'(3), -32768, 32767, -32768);
    send_item(ROLE_QUERY, -30000, -30000, -30000);
    send_item(ROLE_W'(3), -32768, -32768, 32767);
    send_item(ROLE_QUERY, -30000, -30000, -30000);
    send_item(ROLE_QUERY, -32768, -32768, -32767);
  endtask

  task automatic run_random(int quota);
    int start, kind, nq, s, k, c;
    int v [4][3];
    int p [3];
    start = items_sent;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) v[i][j] = 0;
    end
    while (items_sent - start < quota) begin
      kind = $urandom_range(99);
      case ($urandom_range(3))
        0:       s = 40;
        1:       s = 1500;
        default: s = 32767;
      endcase
      if (kind < 8) begin
        send_item(ROLE_W'($urandom_range(7)), rnd16(), rnd16(), rnd16());
      end else if (kind < 14) begin
        k = $urandom_range(3);
        for (int j = 0; j < 3; j++) v[k][j] = rnd_within(s);
        send_item(ROLE_W'(k), v[k][0], v[k][1], v[k][2]);
      end else begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 3; j++) v[i][j] = rnd_within(s);
        end
        if ($urandom_range(99) < 8) begin
          if ($urandom_range(1) == 1) begin
            k = $urandom_range(2);
            for (int j = 0; j < 3; j++) v[3][j] = v[k][j];
          end else begin
            for (int i = 1; i < 4; i++) v[i][2] = v[0][2];
          end
        end
        for (int i = 0; i < 4; i++) send_item(ROLE_W'(i), v[i][0], v[i][1], v[i][2]);
        nq = $urandom_range(1, 8);
        repeat (nq) begin
          k = $urandom_range(3);
          for (int j = 0; j < 3; j++) begin
            c = (v[0][j] + v[1][j] + v[2][j] + v[3][j]) / 4;
            case ($urandom_range(3))
              0:       p[j] = v[k][j];
              3:       p[j] = rnd_within(s);
              default: p[j] = clamp16(c + rnd_within(s / 2 + 1));
            endcase
          end
          send_item(ROLE_QUERY, p[0], p[1], p[2]);
        end
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] slack_plan [4];
    int               idle_plan  [4];
    int               stall_plan [4];
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    hold_off       = 1'b0;
    pressure_armed = 1'b0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    items_sent     = 0;
    slack_plan = '{CFG_W'(0), '1, CFG_W'($urandom_range(1048575)), CFG_W'(1)};
    idle_plan  = '{0, 48, 0, 10};
    stall_plan = '{0, 0, 48, 10};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    settle();
    for (int ph = 0; ph < 4; ph++) begin
      write_slack(slack_plan[ph]);
      src_idle_pct  = idle_plan[ph];
      snk_stall_pct = stall_plan[ph];
      if (ph == 0) pressure_armed = 1'b1;
      run_random(PHASE_ITEMS);
      settle();
    end
    while (sb.pending() > 0) begin
      void'(sb.verdicts.pop_front());
      sb.report("query left without a result at the end of the run");
    end
    $display("covered %0d vertex loads, %0d queries (%0d inside, %0d flat), %0d dropped roles",
             sb.loads, sb.queries, sb.n_inside, sb.n_degen, sb.dropped);
    $display("slack at reset value, 0, max, %0d and 1; idling on either side and one long hold",
             slack_plan[2]);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ptt_pkg.sv
src/ptt_ctrl.sv
src/ptt_datapath.sv
src/point_in_tetrahedron_test.sv
bench/tb.sv
